[src/wsvm_pkg.sv]
// wsvm_pkg: shared types and constants for the wavetable stereo voice mixer
// no dependencies
`default_nettype none
package wsvm_pkg;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_MEM  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [2:0] SEL_BASE  = 3'd0;
  localparam logic [2:0] SEL_LEN   = 3'd1;
  localparam logic [2:0] SEL_LOOP  = 3'd2;
  localparam logic [2:0] SEL_STEP  = 3'd3;
  localparam logic [2:0] SEL_VOL   = 3'd4;
  localparam logic [2:0] SEL_CTRL  = 3'd5;
  localparam logic [2:0] SEL_PHASE = 3'd6;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_MASTER = 2'd1;
  localparam logic [1:0] REG_BITS   = 2'd2;
  localparam logic [1:0] REG_FORMAT = 2'd3;

  localparam logic [1:0] FMT_MONO8    = 2'd0;
  localparam logic [1:0] FMT_MONO16   = 2'd1;
  localparam logic [1:0] FMT_STEREO8  = 2'd2;
  localparam logic [1:0] FMT_STEREO16 = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         voice;
    logic [2:0]         setting_sel;
    logic [31:0]        setting_value;
    logic [7:0]         balance;
    logic [15:0]        mem_addr;
    logic signed [15:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_mix;
    logic signed [31:0] right_mix;
    logic [31:0]        frame_word;
  } out_item_t;

  function automatic logic [1:0] atten_shift(input logic [4:0] n);
    if (n <= 5'd4) return 2'd1;
    else if (n <= 5'd8) return 2'd2;
    else return 2'd3;
  endfunction

endpackage
`default_nettype wire

[src/wavetable_stereo_voice_mixer.sv]
// wavetable_stereo_voice_mixer: top level, configuration registers, front and back
// depends on wsvm_pkg, wsvm_front, wsvm_back
//
// A setting or sample write is done in the idle state as it is taken from the queue.
// A tick is issued from the idle state; each mixed voice then steps through read,
// multiply and accumulate states, and master volume, truncation and the output
// register follow; the output state waits while an earlier result is unaccepted.
// A two-entry queue and an output register let input and output stall independently.
// Configuration is accepted only while no item is queued or being worked on.
`default_nettype none
module wavetable_stereo_voice_mixer #(
  parameter int VOICES = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wsvm_pkg::in_item_t  in_item,
  input  wire                 in_valid,
  output logic                in_ready,
  output wsvm_pkg::out_item_t out_item,
  output logic                out_valid,
  input  wire                 out_ready,
  input  wire [1:0]           cfg_index,
  input  wire [31:0]          cfg_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready
);
  wsvm_pkg::in_item_t q_item;
  logic q_valid, q_take, busy;
  logic [4:0] active_channels;
  logic [7:0] post_gain;
  logic       sample_bits;
  logic [1:0] output_format;

  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= 5'd4;
      post_gain <= 8'd255;
      sample_bits <= 1'b0;
      output_format <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsvm_pkg::REG_ACTIVE: active_channels <= cfg_data[4:0];
        wsvm_pkg::REG_MASTER: post_gain <= cfg_data[7:0];
        wsvm_pkg::REG_BITS:   sample_bits <= cfg_data[0];
        wsvm_pkg::REG_FORMAT: output_format <= cfg_data[1:0];
      endcase
    end
  end

  wsvm_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready, .q_item, .q_valid, .q_take
  );

  wsvm_back #(.VOICES(VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_back (
    .clk, .rst, .q_item, .q_valid, .q_take, .active_channels, .post_gain,
    .sample_bits, .output_format, .out_item, .out_valid, .out_ready, .busy
  );
endmodule
`default_nettype wire

[src/wsvm_front.sv]
// wsvm_front: input stage and small item queue between front and back
// depends on wsvm_pkg
`default_nettype none
module wsvm_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wsvm_pkg::in_item_t  in_item,
  input  wire                 in_valid,
  output logic                in_ready,
  output wsvm_pkg::in_item_t  q_item,
  output logic                q_valid,
  input  wire                 q_take
);
  wsvm_pkg::in_item_t buf_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  // unused commands are dropped at the front
  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready && (in_item.cmd != wsvm_pkg::CMD_NONE);
  assign pop = q_valid && q_take;
  assign q_valid = (count != 2'd0);
  assign q_item = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= in_item;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[src/wsvm_back.sv]
// wsvm_back: executes queued items, walks the voices on a tick, packs the frame
// depends on wsvm_pkg
`default_nettype none
module wsvm_back #(
  parameter int VOICES = 16,
  parameter int SAMPLE_WORDS = 65536
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wsvm_pkg::in_item_t  q_item,
  input  wire                 q_valid,
  output logic                q_take,
  input  wire [4:0]           active_channels,
  input  wire [7:0]           post_gain,
  input  wire                 sample_bits,
  input  wire [1:0]           output_format,
  output wsvm_pkg::out_item_t out_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                busy
);
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int VW = $clog2(VOICES);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_MAST  = 7'b0010000,
    S_PACK  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [15:0] smem [SAMPLE_WORDS];
  logic [15:0] rd_data;

  logic [15:0] v_base  [VOICES];
  logic [15:0] v_len   [VOICES];
  logic [15:0] v_loop  [VOICES];
  logic [31:0] v_step  [VOICES];
  logic [31:0] v_phase [VOICES];
  logic [7:0]  v_lg    [VOICES];
  logic [7:0]  v_rg    [VOICES];
  logic [1:0]  v_ctrl  [VOICES];

  logic [VW-1:0] vi;
  logic [4:0]    vcount, nvoices;
  logic [3:0]    shift;
  logic          playing;
  logic signed [24:0] pl, pr;
  logic signed [39:0] acc_l, acc_r;
  logic signed [49:0] ml, mr;
  logic [31:0] lw, rw, sum, frame;
  logic [15:0] volp_r, volp_l;
  logic [AW-1:0] rd_addr;
  logic [31:0] ph_next;
  logic signed [16:0] samp;

  always_comb begin
    if (active_channels < 5'(VOICES)) nvoices = active_channels;
    else nvoices = 5'(VOICES);
  end

  assign q_take = q_valid && (state == S_IDLE);
  assign busy = (state != S_IDLE) || q_valid;
  assign rd_addr = AW'({16'd0, v_base[vi]} + {16'd0, v_phase[vi][31:16]});
  assign ph_next = v_phase[vi] + v_step[vi];
  assign volp_r = {8'd0, q_item.setting_value[7:0]} * {8'd0, q_item.balance};
  assign volp_l = {8'd0, q_item.setting_value[7:0]} * {8'd0, ~q_item.balance};

  always_comb begin
    if (sample_bits) samp = {rd_data[15], rd_data};
    else samp = {{9{rd_data[7]}}, rd_data[7:0]};
    if (!playing) samp = '0;
  end

  assign sum = lw + rw;
  always_comb begin
    unique case (output_format)
      wsvm_pkg::FMT_MONO8:   frame = {24'd0, ~sum[16], sum[15:9]};
      wsvm_pkg::FMT_MONO16:  frame = {16'd0, sum[16:1]};
      wsvm_pkg::FMT_STEREO8: frame = {16'd0, ~lw[15], lw[14:8], ~rw[15], rw[14:8]};
      default:               frame = {lw[15:0], rw[15:0]};
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take && q_item.cmd == wsvm_pkg::CMD_MEM)
      smem[AW'(q_item.mem_addr)] <= q_item.mem_data;
    rd_data <= smem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        v_base[i] <= '0; v_len[i] <= '0; v_loop[i] <= '0; v_step[i] <= '0;
        v_phase[i] <= '0; v_lg[i] <= '0; v_rg[i] <= '0; v_ctrl[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_take) begin
            if (q_item.cmd == wsvm_pkg::CMD_TICK) begin
              acc_l <= '0;
              acc_r <= '0;
              vi <= '0;
              vcount <= 5'd0;
              shift <= {2'd0, wsvm_pkg::atten_shift(active_channels)}
                       + (sample_bits ? 4'd8 : 4'd0);
              state <= (nvoices == 5'd0) ? S_MAST : S_READ;
            end else if (q_item.cmd == wsvm_pkg::CMD_SET
                         && 32'(q_item.voice) < 32'(VOICES)) begin
              unique case (q_item.setting_sel)
                wsvm_pkg::SEL_BASE:  v_base[VW'(q_item.voice)] <= q_item.setting_value[15:0];
                wsvm_pkg::SEL_LEN:   v_len[VW'(q_item.voice)] <= q_item.setting_value[15:0];
                wsvm_pkg::SEL_LOOP:  v_loop[VW'(q_item.voice)] <= q_item.setting_value[15:0];
                wsvm_pkg::SEL_STEP:  v_step[VW'(q_item.voice)] <= q_item.setting_value;
                wsvm_pkg::SEL_VOL: begin
                  v_rg[VW'(q_item.voice)] <= volp_r[15:8];
                  v_lg[VW'(q_item.voice)] <= volp_l[15:8];
                end
                wsvm_pkg::SEL_CTRL:  v_ctrl[VW'(q_item.voice)] <= q_item.setting_value[1:0];
                wsvm_pkg::SEL_PHASE: v_phase[VW'(q_item.voice)] <= q_item.setting_value;
                default: ;
              endcase
            end
          end
        end
        S_READ: begin
          playing <= v_ctrl[vi][1];
          if (ph_next >= {v_len[vi], 16'd0} && v_ctrl[vi][0])
            v_phase[vi] <= {v_loop[vi], 16'd0};
          else v_phase[vi] <= ph_next;
          if (ph_next >= {v_len[vi], 16'd0} && !v_ctrl[vi][0]) v_ctrl[vi] <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          pl <= samp * $signed({1'b0, v_lg[vi]});
          pr <= samp * $signed({1'b0, v_rg[vi]});
          state <= S_ACC;
        end
        S_ACC: begin
          acc_l <= acc_l + 40'(pl >>> shift);
          acc_r <= acc_r + 40'(pr >>> shift);
          vcount <= vcount + 5'd1;
          vi <= vi + VW'(1);
          state <= (vcount + 5'd1 == nvoices) ? S_MAST : S_READ;
        end
        S_MAST: begin
          ml <= acc_l * $signed({1'b0, {1'b0, post_gain} + 9'd1});
          mr <= acc_r * $signed({1'b0, {1'b0, post_gain} + 9'd1});
          state <= S_PACK;
        end
        S_PACK: begin
          lw <= ml[39:8];
          rw <= mr[39:8];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_item.left_mix <= lw;
            out_item.right_mix <= rw;
            out_item.frame_word <= frame;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[src/wsvm_checker.sv]
// wsvm_checker: port-level assertions for the mixer, bound to the top level
// depends on wsvm_pkg
`default_nettype none
module wsvm_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_ready,
  input wsvm_pkg::out_item_t out_item,
  input wire                 out_valid,
  input wire                 out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("out item dropped");
  a_no_out_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("output after reset");
  a_ready_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready) else $error("not ready after reset");
endmodule

bind wavetable_stereo_voice_mixer wsvm_checker u_chk (
  .clk, .rst, .in_ready, .out_item, .out_valid, .out_ready
);
`default_nettype wire
